@@ rtl/assert_macros.svh @@
// assertion macros shared by the checker files
// each expands to one labelled concurrent assertion clocked on clk, reset on arst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent checked in the same cycle
`define VPS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the next cycle
`define VPS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/vps_pkg.sv @@
// types, constants and codes for the voice prompt sequencer
// used by the controller, the datapath, the top level and the checker
`default_nettype none

package vps_pkg;

	localparam int QUEUE_DEPTH = 12;
	localparam int ALARM_PAIRS = 4;
	localparam int ALARM_STEPS = 3 * ALARM_PAIRS - 1;

	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int STEP_W = $clog2(ALARM_STEPS + 1);

	localparam int CLIP_W     = 32;
	localparam int TICK_W     = 10;
	localparam int HZ_W       = 12;
	localparam int VOL_W      = 5;
	localparam int KIND_W     = 3;
	localparam int CMD_W      = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;

	localparam logic [TICK_W-1:0] SETTLE_RST = TICK_W'(120);
	localparam logic [HZ_W-1:0]   HIGH_RST   = HZ_W'(1200);
	localparam logic [HZ_W-1:0]   LOW_RST    = HZ_W'(600);
	localparam logic [TICK_W-1:0] TONE_RST   = TICK_W'(180);
	localparam logic [TICK_W-1:0] GAP_RST    = TICK_W'(220);
	localparam logic [VOL_W-1:0]  VOL_RST    = VOL_W'(10);

	typedef enum logic [KIND_W-1:0] {
		KIND_TICK     = 3'd0,
		KIND_ANNOUNCE = 3'd1,
		KIND_APPEND   = 3'd2,
		KIND_STOP     = 3'd3,
		KIND_ALARM    = 3'd4
	} kind_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_START    = 2'd0,
		CMD_TONE_ON  = 2'd1,
		CMD_TONE_OFF = 2'd2,
		CMD_STOP     = 2'd3
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SETTLE = 3'd0,
		CFG_HIGH   = 3'd1,
		CFG_LOW    = 3'd2,
		CFG_TONE   = 3'd3,
		CFG_GAP    = 3'd4,
		CFG_VOLUME = 3'd5
	} cfg_idx_t;

	typedef enum logic [1:0] {
		PH_HIGH = 2'd0,
		PH_LOW  = 2'd1,
		PH_GAP  = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		RD_POS      = 2'd0,
		RD_POS_NEXT = 2'd1,
		RD_PEND0    = 2'd2
	} rd_sel_t;

	typedef enum logic {
		CTL_RUN    = 1'b0,
		CTL_SECOND = 1'b1
	} ctl_state_t;

	// controller to datapath
	typedef struct packed {
		logic    quiet_inc;
		logic    quiet_clr;
		logic    pend_first;
		logic    pend_append;
		logic    pend_clr;
		logic    pos_inc;
		logic    swap;
		logic    act_clr;
		logic    alarm_start;
		logic    alarm_dec;
		logic    alarm_fire;
		logic    out_load;
		logic    out_clear;
		cmd_t    out_cmd;
		logic    out_last;
		rd_sel_t rd_sel;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic   out_valid;
		logic   pos_lt;
		logic   posinc_lt;
		logic   pend_nonempty;
		logic   pend_full;
		logic   settled;
		logic   wait_gt1;
		logic   alarm_done;
		phase_t phase;
	} dp_stat_t;

endpackage

`default_nettype wire

@@ rtl/vps_datapath.sv @@
// datapath: configuration registers, the two clip buffers, counters, alarm timing
// and the output register; acts on commands from vps_ctrl, depends on vps_pkg
`default_nettype none

module vps_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [vps_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [vps_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic [vps_pkg::CLIP_W-1:0]       clip_id,
	input  vps_pkg::dp_cmd_t                 cmd,
	output vps_pkg::dp_stat_t                stat,
	output logic                             out_valid,
	output logic [vps_pkg::CMD_W-1:0]        command,
	output logic [vps_pkg::CLIP_W-1:0]       out_clip,
	output logic [vps_pkg::HZ_W-1:0]         tone_hz,
	output logic [vps_pkg::VOL_W-1:0]        volume,
	output logic                             last
);

	logic [vps_pkg::TICK_W-1:0] settle_q, tone_q, gap_q;
	logic [vps_pkg::HZ_W-1:0]   high_q, low_q;
	logic [vps_pkg::VOL_W-1:0]  vol_q;

	// two banks: sel_q names the pending bank, the other one is active
	logic [vps_pkg::CLIP_W-1:0] buf_q [0:1][vps_pkg::QUEUE_DEPTH];
	logic                       sel_q;
	logic [vps_pkg::CNT_W-1:0]  pend_cnt_q, act_cnt_q, pos_q;
	logic [vps_pkg::TICK_W-1:0] quiet_q;
	logic [vps_pkg::STEP_W-1:0] step_q;
	vps_pkg::phase_t            phase_q;
	logic [vps_pkg::TICK_W-1:0] wait_q;

	logic                       out_valid_q, out_last_q;
	vps_pkg::cmd_t              out_cmd_q;
	logic [vps_pkg::CLIP_W-1:0] out_clip_q;
	logic [vps_pkg::HZ_W-1:0]   out_hz_q;
	logic [vps_pkg::VOL_W-1:0]  out_vol_q;

	logic [vps_pkg::CNT_W-1:0]  pos_next;
	logic [vps_pkg::TICK_W-1:0] quiet_inc;
	logic                       rd_bank;
	logic [vps_pkg::IDX_W-1:0]  rd_idx, wr_idx;
	logic [vps_pkg::CLIP_W-1:0] rd_data;

	assign pos_next  = pos_q + vps_pkg::CNT_W'(1);
	assign quiet_inc = (&quiet_q) ? quiet_q : quiet_q + vps_pkg::TICK_W'(1);

	always_comb begin
		stat.out_valid     = out_valid_q;
		stat.pos_lt        = pos_q < act_cnt_q;
		stat.posinc_lt     = pos_next < act_cnt_q;
		stat.pend_nonempty = pend_cnt_q != '0;
		stat.pend_full     = pend_cnt_q == vps_pkg::CNT_W'(vps_pkg::QUEUE_DEPTH);
		stat.settled       = quiet_inc >= settle_q;
		stat.wait_gt1      = wait_q > vps_pkg::TICK_W'(1);
		stat.alarm_done    = step_q >= vps_pkg::STEP_W'(vps_pkg::ALARM_STEPS);
		stat.phase         = phase_q;
	end

	always_comb begin
		unique case (cmd.rd_sel)
			vps_pkg::RD_POS: begin
				rd_bank = ~sel_q;
				rd_idx  = pos_q[vps_pkg::IDX_W-1:0];
			end
			vps_pkg::RD_POS_NEXT: begin
				rd_bank = ~sel_q;
				rd_idx  = pos_next[vps_pkg::IDX_W-1:0];
			end
			vps_pkg::RD_PEND0: begin
				rd_bank = sel_q;
				rd_idx  = '0;
			end
			default: begin
				rd_bank = ~sel_q;
				rd_idx  = pos_q[vps_pkg::IDX_W-1:0];
			end
		endcase
		rd_data = buf_q[rd_bank][rd_idx];
		wr_idx  = cmd.pend_first ? '0 : pend_cnt_q[vps_pkg::IDX_W-1:0];
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= vps_pkg::SETTLE_RST;
			high_q   <= vps_pkg::HIGH_RST;
			low_q    <= vps_pkg::LOW_RST;
			tone_q   <= vps_pkg::TONE_RST;
			gap_q    <= vps_pkg::GAP_RST;
			vol_q    <= vps_pkg::VOL_RST;
		end else if (cfg_we) begin
			unique case (vps_pkg::cfg_idx_t'(cfg_index))
				vps_pkg::CFG_SETTLE: settle_q <= cfg_data[vps_pkg::TICK_W-1:0];
				vps_pkg::CFG_HIGH:   high_q   <= cfg_data[vps_pkg::HZ_W-1:0];
				vps_pkg::CFG_LOW:    low_q    <= cfg_data[vps_pkg::HZ_W-1:0];
				vps_pkg::CFG_TONE:   tone_q   <= cfg_data[vps_pkg::TICK_W-1:0];
				vps_pkg::CFG_GAP:    gap_q    <= cfg_data[vps_pkg::TICK_W-1:0];
				vps_pkg::CFG_VOLUME: vol_q    <= cfg_data[vps_pkg::VOL_W-1:0];
				default: ;
			endcase
		end
	end

	// clip buffers, no reset
	always_ff @(posedge clk) begin
		if (cmd.pend_first || cmd.pend_append) begin
			buf_q[sel_q][wr_idx] <= clip_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q      <= 1'b0;
			pend_cnt_q <= '0;
			act_cnt_q  <= '0;
			pos_q      <= '0;
			quiet_q    <= '0;
		end else begin
			if (cmd.quiet_clr) begin
				quiet_q <= '0;
			end else if (cmd.quiet_inc) begin
				quiet_q <= quiet_inc;
			end

			if (cmd.pend_clr || cmd.swap) begin
				pend_cnt_q <= '0;
			end else if (cmd.pend_first) begin
				pend_cnt_q <= vps_pkg::CNT_W'(1);
			end else if (cmd.pend_append) begin
				pend_cnt_q <= pend_cnt_q + vps_pkg::CNT_W'(1);
			end

			if (cmd.swap) begin
				sel_q     <= ~sel_q;
				act_cnt_q <= pend_cnt_q;
				pos_q     <= '0;
			end else if (cmd.act_clr) begin
				act_cnt_q <= '0;
				pos_q     <= '0;
			end else if (cmd.pos_inc) begin
				pos_q <= pos_next;
			end
		end
	end

	// alarm warble timing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= '0;
			phase_q <= vps_pkg::PH_HIGH;
			wait_q  <= '0;
		end else if (cmd.alarm_start) begin
			step_q  <= '0;
			phase_q <= vps_pkg::PH_HIGH;
			wait_q  <= '0;
		end else if (cmd.alarm_fire) begin
			step_q <= step_q + vps_pkg::STEP_W'(1);
			wait_q <= (phase_q == vps_pkg::PH_GAP) ? gap_q : tone_q;
			unique case (phase_q)
				vps_pkg::PH_HIGH: phase_q <= vps_pkg::PH_LOW;
				vps_pkg::PH_LOW:  phase_q <= vps_pkg::PH_GAP;
				default:          phase_q <= vps_pkg::PH_HIGH;
			endcase
		end else if (cmd.alarm_dec && wait_q != '0) begin
			wait_q <= wait_q - vps_pkg::TICK_W'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (cmd.out_clear) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_cmd_q  <= cmd.out_cmd;
			out_last_q <= cmd.out_last;
			out_clip_q <= (cmd.out_cmd == vps_pkg::CMD_START) ? rd_data : '0;
			if (cmd.out_cmd == vps_pkg::CMD_TONE_ON) begin
				out_hz_q <= (phase_q == vps_pkg::PH_HIGH) ? high_q : low_q;
			end else begin
				out_hz_q <= '0;
			end
			if (cmd.out_cmd == vps_pkg::CMD_TONE_ON || cmd.out_cmd == vps_pkg::CMD_TONE_OFF) begin
				out_vol_q <= vol_q;
			end else begin
				out_vol_q <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign command   = out_cmd_q;
	assign out_clip  = out_clip_q;
	assign tone_hz   = out_hz_q;
	assign volume    = out_vol_q;
	assign last      = out_last_q;

endmodule

`default_nettype wire

@@ rtl/vps_ctrl.sv @@
// controller: decodes each input beat, keeps alarm and playback flags, sequences
// the second result of a stop; drives vps_datapath via vps_pkg::dp_cmd_t
`default_nettype none

module vps_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [vps_pkg::KIND_W-1:0]    kind,
	input  logic                          id_valid,
	input  logic                          decoder_busy,
	input  logic                          out_stall,
	input  vps_pkg::dp_stat_t             stat,
	output logic                          in_stall,
	output vps_pkg::dp_cmd_t              cmd
);

	vps_pkg::ctl_state_t state_q, state_d;
	logic                alarm_on_q, alarm_on_d;
	logic                playing_q, playing_d;
	logic                accept, out_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= vps_pkg::CTL_RUN;
			alarm_on_q <= 1'b0;
			playing_q  <= 1'b0;
		end else begin
			state_q    <= state_d;
			alarm_on_q <= alarm_on_d;
			playing_q  <= playing_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		alarm_on_d = alarm_on_q;
		playing_d  = playing_q;
		cmd        = '0;

		// one output slot: take input only when it is free or being emptied
		in_stall      = (state_q == vps_pkg::CTL_SECOND) || (stat.out_valid && out_stall);
		accept        = in_valid && !in_stall;
		out_take      = stat.out_valid && !out_stall;
		cmd.out_clear = out_take;

		unique case (state_q)
			vps_pkg::CTL_SECOND: begin
				if (out_take) begin
					cmd.out_load = 1'b1;
					cmd.out_cmd  = vps_pkg::CMD_STOP;
					cmd.out_last = 1'b1;
					state_d      = vps_pkg::CTL_RUN;
				end
			end
			vps_pkg::CTL_RUN: begin
				if (accept) begin
					unique case (vps_pkg::kind_t'(kind))
						vps_pkg::KIND_TICK: begin
							cmd.quiet_inc = 1'b1;
							if (alarm_on_q) begin
								if (stat.wait_gt1) begin
									cmd.alarm_dec = 1'b1;
								end else if (stat.alarm_done) begin
									cmd.alarm_dec = 1'b1;
									cmd.out_load  = 1'b1;
									cmd.out_cmd   = vps_pkg::CMD_TONE_OFF;
									cmd.out_last  = 1'b1;
									alarm_on_d    = 1'b0;
								end else begin
									cmd.alarm_fire = 1'b1;
									cmd.out_load   = 1'b1;
									cmd.out_last   = 1'b1;
									cmd.out_cmd    = (stat.phase == vps_pkg::PH_GAP) ?
										vps_pkg::CMD_TONE_OFF : vps_pkg::CMD_TONE_ON;
								end
							end else if (!(playing_q && decoder_busy)) begin
								// current clip done: move on, else swap in a settled utterance
								cmd.pos_inc = playing_q;
								playing_d   = 1'b0;
								if (playing_q ? stat.posinc_lt : stat.pos_lt) begin
									playing_d    = 1'b1;
									cmd.out_load = 1'b1;
									cmd.out_cmd  = vps_pkg::CMD_START;
									cmd.out_last = 1'b1;
									cmd.rd_sel   = playing_q ? vps_pkg::RD_POS_NEXT :
										vps_pkg::RD_POS;
								end else if (stat.pend_nonempty && stat.settled) begin
									playing_d    = 1'b1;
									cmd.swap     = 1'b1;
									cmd.out_load = 1'b1;
									cmd.out_cmd  = vps_pkg::CMD_START;
									cmd.out_last = 1'b1;
									cmd.rd_sel   = vps_pkg::RD_PEND0;
								end
							end
						end
						vps_pkg::KIND_ANNOUNCE: begin
							cmd.quiet_clr  = 1'b1;
							cmd.pend_first = id_valid;
							cmd.pend_clr   = !id_valid;
						end
						vps_pkg::KIND_APPEND: begin
							if (id_valid && !stat.pend_full) begin
								cmd.pend_append = 1'b1;
								cmd.quiet_clr   = 1'b1;
							end
						end
						vps_pkg::KIND_STOP: begin
							cmd.pend_clr = 1'b1;
							cmd.act_clr  = 1'b1;
							playing_d    = 1'b0;
							cmd.out_load = 1'b1;
							if (alarm_on_q) begin
								cmd.out_cmd  = vps_pkg::CMD_TONE_OFF;
								cmd.out_last = 1'b0;
								alarm_on_d   = 1'b0;
								state_d      = vps_pkg::CTL_SECOND;
							end else begin
								cmd.out_cmd  = vps_pkg::CMD_STOP;
								cmd.out_last = 1'b1;
							end
						end
						vps_pkg::KIND_ALARM: begin
							cmd.alarm_start = 1'b1;
							alarm_on_d      = 1'b1;
						end
						default: ;
					endcase
				end
			end
			default: state_d = vps_pkg::CTL_RUN;
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/voice_prompt_sequencer.sv @@
// top level of the voice prompt sequencer: vps_ctrl plus vps_datapath
// depends on vps_pkg
`default_nettype none

// Plays utterances of 32-bit clip ids and an alarm warble on the sidetone. Each
// input beat (tick, announce, append, stop, alarm) is handled in the cycle it is
// accepted, so the block takes one item per clock; the single output register is
// what paces it: an input beat is accepted whenever that register is empty or is
// being emptied in the same cycle. A stop during an alarm yields two result beats
// (tone off, then stop voice), and input stays stalled until the first of them is
// taken. Buffer swap is a bank flip, not a copy. Configuration is always ready and
// should be written only while the block is idle; clip buffers hold no reset value.

module voice_prompt_sequencer (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [vps_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [vps_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [vps_pkg::KIND_W-1:0]       kind,
	input  logic [vps_pkg::CLIP_W-1:0]       clip_id,
	input  logic                             id_valid,
	input  logic                             decoder_busy,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [vps_pkg::CMD_W-1:0]        command,
	output logic [vps_pkg::CLIP_W-1:0]       out_clip,
	output logic [vps_pkg::HZ_W-1:0]         tone_hz,
	output logic [vps_pkg::VOL_W-1:0]        volume,
	output logic                             last
);

	vps_pkg::dp_cmd_t  dp_cmd;
	vps_pkg::dp_stat_t dp_stat;

	assign cfg_ready = 1'b1;

	vps_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.kind         (kind),
		.id_valid     (id_valid),
		.decoder_busy (decoder_busy),
		.out_stall    (out_stall),
		.stat         (dp_stat),
		.in_stall     (in_stall),
		.cmd          (dp_cmd)
	);

	vps_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.clip_id   (clip_id),
		.cmd       (dp_cmd),
		.stat      (dp_stat),
		.out_valid (out_valid),
		.command   (command),
		.out_clip  (out_clip),
		.tone_hz   (tone_hz),
		.volume    (volume),
		.last      (last)
	);

endmodule

`default_nettype wire

@@ rtl/vps_checker.sv @@
// port-level checker for voice_prompt_sequencer, bound to the top level
// depends on vps_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module vps_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_stall,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic [vps_pkg::CMD_W-1:0]        command,
	input logic [vps_pkg::CLIP_W-1:0]       out_clip,
	input logic [vps_pkg::HZ_W-1:0]         tone_hz,
	input logic [vps_pkg::VOL_W-1:0]        volume,
	input logic                             last
);

	`VPS_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(command) && $stable(out_clip) && $stable(last),
		"stalled result beat changed")

	`VPS_ASSERT_NOW(a_full_slot_stalls, out_valid && out_stall, in_stall,
		"input taken while the result register is blocked")

	`VPS_ASSERT_NOW(a_pair_stalls, out_valid && !last, in_stall,
		"input taken while a second result is owed")

	`VPS_ASSERT_NEXT(a_stop_follows, out_valid && !out_stall && !last,
		out_valid && command == vps_pkg::CMD_STOP && last,
		"tone off of a stop not followed by stop voice")

	`VPS_ASSERT_NOW(a_start_clean, out_valid && command == vps_pkg::CMD_START,
		tone_hz == '0 && volume == '0,
		"start clip beat carries tone fields")

endmodule

bind voice_prompt_sequencer vps_checker u_vps_checker (.*);

`default_nettype wire
